FILE: rtl/ils_pkg.sv
// ils_pkg: shared widths, request and status codes, and the command and status
// structs exchanged between the list controller and its datapath.
// No dependencies.
package ils_pkg;

  localparam int DEF_CAPACITY = 16;

  localparam int KIND_W   = 3;
  localparam int POS_W    = 5;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  localparam logic [KIND_W-1:0] KIND_INS_HEAD = 3'd0;
  localparam logic [KIND_W-1:0] KIND_INS_TAIL = 3'd1;
  localparam logic [KIND_W-1:0] KIND_INS_AT   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DEL_HEAD = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DEL_TAIL = 3'd4;
  localparam logic [KIND_W-1:0] KIND_DEL_AT   = 3'd5;
  localparam logic [KIND_W-1:0] KIND_READ     = 3'd6;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

  localparam logic signed [VAL_W-1:0] RD_INVALID = '1;
  localparam logic signed [VAL_W-1:0] RD_NONE    = '0;

  typedef struct packed {
    logic take;
    logic decide;
    logic mem_rd;
    logic move_wr;
    logic put;
    logic trim;
    logic load_out;
  } ils_cmd_t;

  typedef struct packed {
    logic is_ins;
    logic is_rd;
    logic go;
    logic more;
    logic out_free;
  } ils_sts_t;

endpackage

FILE: rtl/ils_ctrl.sv
// ils_ctrl: request sequencer for the list store; steps one word move at a
// time through the datapath. Depends on ils_pkg.
module ils_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ils_pkg::ils_sts_t sts,
  output ils_pkg::ils_cmd_t cmd
);
  import ils_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_CHECK   = 9'b000000010,
    S_STEP    = 9'b000000100,
    S_MOVE_RD = 9'b000001000,
    S_MOVE_WR = 9'b000010000,
    S_PUT     = 9'b000100000,
    S_TRIM    = 9'b001000000,
    S_FETCH   = 9'b010000000,
    S_DONE    = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.decide = 1'b1;
        if (!sts.go) begin
          state_nxt = S_DONE;
        end else if (sts.is_rd) begin
          state_nxt = S_FETCH;
        end else begin
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        if (sts.more) begin
          state_nxt = S_MOVE_RD;
        end else if (sts.is_ins) begin
          state_nxt = S_PUT;
        end else begin
          state_nxt = S_TRIM;
        end
      end
      S_MOVE_RD: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = S_MOVE_WR;
      end
      S_MOVE_WR: begin
        cmd.move_wr = 1'b1;
        state_nxt   = S_STEP;
      end
      S_PUT: begin
        cmd.put   = 1'b1;
        state_nxt = S_DONE;
      end
      S_TRIM: begin
        cmd.trim  = 1'b1;
        state_nxt = S_DONE;
      end
      S_FETCH: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

FILE: rtl/ils_dp.sv
// ils_dp: list datapath: entry memory, count, cursor, request and result
// registers. Driven by ils_ctrl commands; depends on ils_pkg.
module ils_dp #(
  parameter int CAPACITY = ils_pkg::DEF_CAPACITY
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ils_pkg::ils_cmd_t                   cmd,
  output ils_pkg::ils_sts_t                   sts,
  input  logic        [ils_pkg::KIND_W-1:0]   in_kind,
  input  logic        [ils_pkg::POS_W-1:0]    in_position,
  input  logic signed [ils_pkg::VAL_W-1:0]    in_item_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic        [ils_pkg::STATUS_W-1:0] out_status,
  output logic signed [ils_pkg::VAL_W-1:0]    out_read_value,
  output logic        [ils_pkg::COUNT_W-1:0]  out_entry_count
);
  import ils_pkg::*;

  localparam int IW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  logic        [VAL_W-1:0]    mem [CAPACITY];
  logic        [VAL_W-1:0]    rdata_r;

  logic        [KIND_W-1:0]   kind_r;
  logic        [POS_W-1:0]    pos_r;
  logic signed [VAL_W-1:0]    value_r;
  logic        [CW-1:0]       count_r;
  logic        [CMPW-1:0]     idx_r;
  logic        [CMPW-1:0]     cursor_r;
  logic        [STATUS_W-1:0] st_r;

  logic                       out_valid_r;
  logic        [STATUS_W-1:0] out_status_r;
  logic signed [VAL_W-1:0]    out_read_value_r;
  logic        [COUNT_W-1:0]  out_count_r;

  logic                       is_ins, is_del, is_rd;
  logic        [CMPW-1:0]     count_ext, pos_ext, idx_c, cursor_dn, cursor_up;
  logic        [STATUS_W-1:0] st_c;
  logic        [IW-1:0]       rd_addr;

  assign count_ext = CMPW'(count_r);
  assign pos_ext   = CMPW'(pos_r);
  assign cursor_dn = cursor_r - CMPW'(1);
  assign cursor_up = cursor_r + CMPW'(1);

  always_comb begin
    is_ins = 1'b0;
    is_del = 1'b0;
    is_rd  = 1'b0;
    idx_c  = pos_ext;
    case (kind_r)
      KIND_INS_HEAD: begin is_ins = 1'b1; idx_c = '0;                         end
      KIND_INS_TAIL: begin is_ins = 1'b1; idx_c = count_ext;                  end
      KIND_INS_AT:   begin is_ins = 1'b1; idx_c = pos_ext;                    end
      KIND_DEL_HEAD: begin is_del = 1'b1; idx_c = '0;                         end
      KIND_DEL_TAIL: begin is_del = 1'b1; idx_c = count_ext - CMPW'(1);       end
      KIND_DEL_AT:   begin is_del = 1'b1; idx_c = pos_ext;                    end
      KIND_READ:     begin is_rd  = 1'b1; idx_c = pos_ext;                    end
      default:       begin idx_c = pos_ext;                                   end
    endcase
  end

  always_comb begin
    st_c = ST_OK;
    if (is_ins) begin
      if (idx_c > count_ext) begin
        st_c = ST_BAD_INDEX;
      end else if (count_r >= CW'(CAPACITY)) begin
        st_c = ST_FULL;
      end
    end else if (is_del) begin
      if (count_r == '0) begin
        st_c = ST_EMPTY;
      end else if (idx_c >= count_ext) begin
        st_c = ST_BAD_INDEX;
      end
    end else if (is_rd) begin
      if (idx_c >= count_ext) begin
        st_c = ST_BAD_INDEX;
      end
    end
  end

  always_comb begin
    sts.is_ins   = is_ins;
    sts.is_rd    = is_rd;
    sts.go       = (st_c == ST_OK) && (is_ins || is_del || is_rd);
    sts.more     = is_ins ? (cursor_r > idx_r) : (cursor_up < count_ext);
    sts.out_free = !out_valid_r || !out_stall;
  end

  always_comb begin
    if (is_rd) begin
      rd_addr = idx_r[IW-1:0];
    end else if (is_ins) begin
      rd_addr = cursor_dn[IW-1:0];
    end else begin
      rd_addr = cursor_up[IW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_rd) begin
      rdata_r <= mem[rd_addr];
    end
    if (cmd.move_wr) begin
      mem[cursor_r[IW-1:0]] <= rdata_r;
    end else if (cmd.put) begin
      mem[idx_r[IW-1:0]] <= value_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      kind_r  <= in_kind;
      pos_r   <= in_position;
      value_r <= in_item_value;
    end
    if (cmd.decide) begin
      st_r     <= st_c;
      idx_r    <= idx_c;
      cursor_r <= is_ins ? count_ext : idx_c;
    end else if (cmd.move_wr) begin
      cursor_r <= is_ins ? cursor_dn : cursor_up;
    end
    if (cmd.load_out) begin
      out_status_r <= st_r;
      out_count_r  <= COUNT_W'(count_r);
      if (!is_rd) begin
        out_read_value_r <= RD_NONE;
      end else if (st_r == ST_OK) begin
        out_read_value_r <= rdata_r;
      end else begin
        out_read_value_r <= RD_INVALID;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.put) begin
        count_r <= count_r + CW'(1);
      end else if (cmd.trim) begin
        count_r <= count_r - CW'(1);
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_read_value  = out_read_value_r;
  assign out_entry_count = out_count_r;

endmodule

FILE: rtl/indexed_list_store_unit.sv
// indexed_list_store_unit: ordered list of signed words with insert, delete
// and read at head, tail or index. Built from ils_ctrl and ils_dp; uses ils_pkg.
//
//   channel  | ports                                         | direction
//   ---------+-----------------------------------------------+----------
//   request  | in_valid in_stall in_kind in_position          | in
//            | in_item_value                                  |
//   result   | out_valid out_stall out_status out_read_value  | out
//            | out_entry_count                                |
//
// One request at a time. A rejected request or unused kind goes straight to
// the result, a read fetches its word first, and an insert or delete that
// moves k words ends with a put or trim; each moved word costs a read, a
// write and a loop check on the single entry memory port. Reset (rst_n low,
// synchronous) empties the list; no clearing pass. A stalled result is held
// in the output register while the next request is accepted and worked on.
module indexed_list_store_unit #(
  parameter int CAPACITY = ils_pkg::DEF_CAPACITY
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic        [ils_pkg::KIND_W-1:0]   in_kind,
  input  logic        [ils_pkg::POS_W-1:0]    in_position,
  input  logic signed [ils_pkg::VAL_W-1:0]    in_item_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic        [ils_pkg::STATUS_W-1:0] out_status,
  output logic signed [ils_pkg::VAL_W-1:0]    out_read_value,
  output logic        [ils_pkg::COUNT_W-1:0]  out_entry_count
);
  import ils_pkg::*;

  ils_cmd_t cmd;
  ils_sts_t sts;

  ils_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ils_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_kind         (in_kind),
    .in_position     (in_position),
    .in_item_value   (in_item_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_read_value  (out_read_value),
    .out_entry_count (out_entry_count)
  );

endmodule

FILE: verif/ils_checker.sv
`timescale 1ns / 100ps
// ils_checker: watches the request and result channels of the list store and
// keeps a shadow list to predict each result, then compares results in order.
// Depends on ils_pkg for widths and request and status codes.
module ils_checker #(
  parameter int CAPACITY = ils_pkg::DEF_CAPACITY
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic        [ils_pkg::KIND_W-1:0]   in_kind,
  input  logic        [ils_pkg::POS_W-1:0]    in_position,
  input  logic signed [ils_pkg::VAL_W-1:0]    in_item_value,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic        [ils_pkg::STATUS_W-1:0] out_status,
  input  logic signed [ils_pkg::VAL_W-1:0]    out_read_value,
  input  logic        [ils_pkg::COUNT_W-1:0]  out_entry_count,
  output int unsigned                         fail_count,
  output int unsigned                         pending
);
  import ils_pkg::*;

  typedef struct packed {
    logic        [STATUS_W-1:0] status;
    logic signed [VAL_W-1:0]    read_value;
    logic        [COUNT_W-1:0]  entry_count;
  } list_result_t;

  logic signed [VAL_W-1:0] shadow_words [CAPACITY];
  int                      shadow_count;
  list_result_t            result_q [$];
  int unsigned             errors;
  int unsigned             reported;

  function automatic logic [STATUS_W-1:0] insert_word(input int idx,
                                                      input logic signed [VAL_W-1:0] word);
    if (idx > shadow_count) return ST_BAD_INDEX;
    if (shadow_count >= CAPACITY) return ST_FULL;
    for (int i = shadow_count; i > idx; i--) shadow_words[i] = shadow_words[i-1];
    shadow_words[idx] = word;
    shadow_count++;
    return ST_OK;
  endfunction

  function automatic logic [STATUS_W-1:0] remove_word(input int idx);
    if (shadow_count == 0) return ST_EMPTY;
    if (idx >= shadow_count) return ST_BAD_INDEX;
    for (int i = idx; i + 1 < shadow_count; i++) shadow_words[i] = shadow_words[i+1];
    shadow_count--;
    return ST_OK;
  endfunction

  task automatic predict_result(input logic [KIND_W-1:0] kind,
                                input logic [POS_W-1:0] pos,
                                input logic signed [VAL_W-1:0] word,
                                output list_result_t res);
    res.status     = ST_OK;
    res.read_value = RD_NONE;
    case (kind)
      KIND_INS_HEAD: res.status = insert_word(0, word);
      KIND_INS_TAIL: res.status = insert_word(shadow_count, word);
      KIND_INS_AT:   res.status = insert_word(int'(pos), word);
      KIND_DEL_HEAD: res.status = remove_word(0);
      KIND_DEL_TAIL: res.status = (shadow_count == 0) ? ST_EMPTY : remove_word(shadow_count - 1);
      KIND_DEL_AT:   res.status = remove_word(int'(pos));
      KIND_READ: begin
        if (int'(pos) >= shadow_count) begin
          res.status     = ST_BAD_INDEX;
          res.read_value = RD_INVALID;
        end else begin
          res.read_value = shadow_words[pos];
        end
      end
      default: ;
    endcase
    res.entry_count = COUNT_W'(shadow_count);
  endtask

  always @(posedge clk) begin
    list_result_t got;
    list_result_t want;
    if (!rst_n) begin
      shadow_count = 0;
      result_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = '{out_status, out_read_value, out_entry_count};
        if (result_q.size() == 0) begin
          errors++;
          if (reported < 10)
            $display("%0t: unexpected result status %0d read %0d count %0d",
                     $realtime, got.status, got.read_value, got.entry_count);
          reported++;
        end else begin
          want = result_q.pop_front();
          if (got !== want) begin
            errors++;
            if (reported < 10)
              $display("%0t: mismatch exp status %0d read %0d count %0d, got %0d %0d %0d",
                       $realtime, want.status, want.read_value, want.entry_count,
                       got.status, got.read_value, got.entry_count);
            reported++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        predict_result(in_kind, in_position, in_item_value, want);
        result_q.push_back(want);
      end
    end
    pending    <= result_q.size();
    fail_count <= errors;
  end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// tb_top: clock, reset and request stimulus for indexed_list_store_unit, with
// ils_checker beside the block. Depends on ils_pkg, the block and ils_checker.
module tb_top;
  import ils_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;
  localparam int RAND_WORDS  = 1600;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_START  = 3000;
  localparam int HOLD_LEN    = 500;
  localparam int DRAIN       = 50;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic        [KIND_W-1:0]   in_kind = '0;
  logic        [POS_W-1:0]    in_position = '0;
  logic signed [VAL_W-1:0]    in_item_value = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic        [STATUS_W-1:0] out_status;
  logic signed [VAL_W-1:0]    out_read_value;
  logic        [COUNT_W-1:0]  out_entry_count;
  int unsigned                fail_count;
  int unsigned                pending;
  logic                       tx_quiet = 1'b0;
  int                         cycle_count = 0;
  int                         rx_cycles = 0;

  indexed_list_store_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_position    (in_position),
    .in_item_value  (in_item_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_read_value (out_read_value),
    .out_entry_count(out_entry_count)
  );

  ils_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_position    (in_position),
    .in_item_value  (in_item_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_read_value (out_read_value),
    .out_entry_count(out_entry_count),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[indexed_list_store_unit] ERROR");
    $finish;
  end

  // hold off the result side for a long stretch, then a quiet window
  initial begin
    forever begin
      @(posedge clk);
      rx_cycles++;
      if (rx_cycles >= HOLD_START && rx_cycles < HOLD_START + HOLD_LEN)
        out_stall <= 1'b1;
      else if (rx_cycles >= 8000 && rx_cycles < 14000)
        out_stall <= 1'b0;
      else
        out_stall <= ($urandom_range(99) < 8);
    end
  end

  function automatic logic signed [VAL_W-1:0] pick_word();
    case ($urandom_range(19))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2:       return -32'sd1;
      3:       return 32'sd0;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_word(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] pos,
                           input logic signed [VAL_W-1:0] word);
    while (!tx_quiet && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_kind       <= kind;
    in_position   <= pos;
    in_item_value <= word;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  initial begin
    int                bias;
    int                roll;
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  pos;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(KIND_READ, 5'd0, 32'sd5);
    send_word(KIND_DEL_HEAD, 5'd0, 32'sd0);
    send_word(KIND_DEL_TAIL, 5'd0, 32'sd0);
    send_word(KIND_DEL_AT, 5'd0, 32'sd0);
    send_word(KIND_UNUSED, 5'd16, -32'sd1);
    send_word(KIND_INS_AT, 5'd1, 32'sd9);
    send_word(KIND_INS_TAIL, 5'd0, 32'sh80000000);
    send_word(KIND_DEL_TAIL, 5'd0, 32'sd0);
    send_word(KIND_INS_HEAD, 5'd0, 32'sh7fffffff);
    send_word(KIND_INS_AT, 5'd1, -32'sd1);
    send_word(KIND_INS_AT, 5'd0, 32'sd0);
    send_word(KIND_READ, 5'd2, 32'sd0);
    send_word(KIND_READ, 5'd3, 32'sd0);
    send_word(KIND_DEL_AT, 5'd3, 32'sd0);
    send_word(KIND_DEL_AT, 5'd1, 32'sd0);
    for (int i = 0; i < 14; i++)
      send_word(i[0] ? KIND_INS_TAIL : KIND_INS_HEAD, 5'd0, pick_word());
    send_word(KIND_INS_HEAD, 5'd0, 32'sd1);
    send_word(KIND_INS_AT, 5'd16, 32'sd2);
    send_word(KIND_READ, 5'd15, 32'sd0);
    send_word(KIND_READ, 5'd16, 32'sd0);
    send_word(KIND_DEL_AT, 5'd15, 32'sd0);
    send_word(KIND_INS_AT, 5'd16, 32'sd3);
    send_word(KIND_DEL_AT, 5'd0, 32'sd0);

    bias = 0;
    for (int n = 0; n < RAND_WORDS; n++) begin
      if (n % 64 == 0) bias = $urandom_range(2);
      tx_quiet = (n >= 600 && n < 900);
      roll = $urandom_range(99);
      if (roll == 99)
        kind = KIND_UNUSED;
      else if (roll < (bias == 0 ? 60 : bias == 1 ? 20 : 35))
        kind = KIND_W'($urandom_range(KIND_INS_AT, KIND_INS_HEAD));
      else if (roll < (bias == 0 ? 80 : bias == 1 ? 40 : 65))
        kind = KIND_READ;
      else
        kind = KIND_W'($urandom_range(KIND_DEL_AT, KIND_DEL_HEAD));
      pos = $urandom_range(1) ? POS_W'($urandom_range(16)) : POS_W'($urandom_range(4));
      send_word(kind, pos, pick_word());
    end
    in_valid <= 1'b0;
    tx_quiet = 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("[indexed_list_store_unit] OK");
    else
      $display("[indexed_list_store_unit] ERROR");
    $finish;
  end

endmodule
